FILE: hw/rtl/lfsr_toeplitz_digest8_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LFSR Toeplitz digest core.
// Short forms for clocked implications with a reset disable.
// ----------------------------------------------------------------------------
`ifndef LFSR_TOEPLITZ_DIGEST8_CORE_ASSERT_SVH
`define LFSR_TOEPLITZ_DIGEST8_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTD8_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LTD8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/ltd8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd8_pkg
// Shared types and register indexes of the LFSR Toeplitz digest core.
// ----------------------------------------------------------------------------
package ltd8_pkg;

   localparam int unsigned KeyWidth   = 8;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned IndexWidth = 3;

   localparam logic [IndexWidth-1:0] RegGenerator  = 3'd0;
   localparam logic [IndexWidth-1:0] RegInitialKey = 3'd1;
   localparam logic [IndexWidth-1:0] RegLfsrKind   = 3'd2;
   localparam logic [IndexWidth-1:0] RegShiftLeft  = 3'd3;
   localparam logic [IndexWidth-1:0] RegMsbFirst   = 3'd4;

   typedef struct packed {
      logic [KeyWidth-1:0] generator;
      logic [KeyWidth-1:0] initial_key;
      logic                lfsr_kind;
      logic                shift_left;
      logic                msb_first;
   } cfg_type;

   typedef struct packed {
      logic [KeyWidth-1:0] key;
      logic [KeyWidth-1:0] sum;
      logic [KeyWidth-1:0] xr;
   } acc_type;

endpackage

FILE: hw/rtl/ltd8_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd8_cell
// One data bit step: conditional key accumulation followed by one LFSR step.
// ----------------------------------------------------------------------------
module ltd8_cell (
   input  ltd8_pkg::cfg_type cfg,
   input  logic              data_bit,
   input  ltd8_pkg::acc_type acc_i,
   output ltd8_pkg::acc_type acc_o
);

   always_comb begin
      logic                          parity;
      logic [ltd8_pkg::KeyWidth-1:0] key;

      key    = acc_i.key;
      parity = ^(key & cfg.generator);

      acc_o.sum = data_bit ? acc_i.sum + key : acc_i.sum;
      acc_o.xr  = data_bit ? acc_i.xr ^ key : acc_i.xr;

      if (cfg.lfsr_kind) begin
         if (cfg.shift_left) begin
            acc_o.key = {key[ltd8_pkg::KeyWidth-2:0], parity};
         end else begin
            acc_o.key = {parity, key[ltd8_pkg::KeyWidth-1:1]};
         end
      end else begin
         if (cfg.shift_left) begin
            acc_o.key = {key[ltd8_pkg::KeyWidth-2:0], 1'b0}
                        ^ (key[ltd8_pkg::KeyWidth-1] ? cfg.generator : '0);
         end else begin
            acc_o.key = {1'b0, key[ltd8_pkg::KeyWidth-1:1]}
                        ^ (key[0] ? cfg.generator : '0);
         end
      end
   end

endmodule

FILE: hw/rtl/lfsr_toeplitz_digest8_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr_toeplitz_digest8_core
// Streams message bytes through an 8-bit LFSR Toeplitz hash and returns the
// running sum and xor digests after every byte.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/ready      byte_value, message_start
//   rsp_      out         rsp_valid/ready      digest_sum, digest_xor
//   csr_      in          csr_wr_en            csr_index, csr_wr_data
//
// A row of eight bit cells processes an item; one item is accepted per cycle
// while req_ready is high, and its result is registered in the output stages.
// An output register with a skid stage lets one more item be accepted while
// a result waits; req_ready drops only when both hold results.
// Synchronous reset clears the key, the digests, the registers and the
// output valid bits.
// ----------------------------------------------------------------------------
module lfsr_toeplitz_digest8_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ltd8_pkg::ByteWidth-1:0]       req_byte_value,
   input  logic                                 req_message_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ltd8_pkg::KeyWidth-1:0]        rsp_digest_sum,
   output logic [ltd8_pkg::KeyWidth-1:0]        rsp_digest_xor,
   input  logic                                 csr_wr_en,
   input  logic [ltd8_pkg::IndexWidth-1:0]      csr_index,
   input  logic [ltd8_pkg::KeyWidth-1:0]        csr_wr_data
);

   ltd8_pkg::cfg_type cfg_ff;
   ltd8_pkg::cfg_type cfg_in;
   ltd8_pkg::acc_type state_ff;
   ltd8_pkg::acc_type state_in;
   ltd8_pkg::acc_type chain [0:ltd8_pkg::ByteWidth];
   logic [ltd8_pkg::ByteWidth-1:0] bits;

   logic                              main_valid_ff, main_valid_in;
   logic                              skid_valid_ff, skid_valid_in;
   logic [2*ltd8_pkg::KeyWidth-1:0]   main_data_ff, main_data_in;
   logic [2*ltd8_pkg::KeyWidth-1:0]   skid_data_ff, skid_data_in;
   logic [2*ltd8_pkg::KeyWidth-1:0]   result;
   logic                              push;
   logic                              pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ltd8_pkg::RegGenerator:  cfg_in.generator   = csr_wr_data;
            ltd8_pkg::RegInitialKey: cfg_in.initial_key = csr_wr_data;
            ltd8_pkg::RegLfsrKind:   cfg_in.lfsr_kind   = csr_wr_data[0];
            ltd8_pkg::RegShiftLeft:  cfg_in.shift_left  = csr_wr_data[0];
            ltd8_pkg::RegMsbFirst:   cfg_in.msb_first   = csr_wr_data[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      if (req_message_start) begin
         chain[0].key = cfg_ff.initial_key;
         chain[0].sum = '0;
         chain[0].xr  = '0;
      end else begin
         chain[0] = state_ff;
      end
   end

   for (genvar i = 0; i < ltd8_pkg::ByteWidth; i++) begin : g_cell
      assign bits[i] = cfg_ff.msb_first ? req_byte_value[ltd8_pkg::ByteWidth-1-i]
                                        : req_byte_value[i];
      ltd8_cell u_cell (
         .cfg      (cfg_ff),
         .data_bit (bits[i]),
         .acc_i    (chain[i]),
         .acc_o    (chain[i+1])
      );
   end

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = main_valid_ff && rsp_ready;
   assign result    = {chain[ltd8_pkg::ByteWidth].sum, chain[ltd8_pkg::ByteWidth].xr};
   assign state_in  = push ? chain[ltd8_pkg::ByteWidth] : state_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = result;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         state_ff      <= '0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = main_valid_ff;
   assign rsp_digest_sum = main_data_ff[2*ltd8_pkg::KeyWidth-1:ltd8_pkg::KeyWidth];
   assign rsp_digest_xor = main_data_ff[ltd8_pkg::KeyWidth-1:0];

endmodule

FILE: hw/rtl/ltd8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltd8_checker
// Port-level checks of the LFSR Toeplitz digest core, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfsr_toeplitz_digest8_core_assert.svh"

module ltd8_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [ltd8_pkg::ByteWidth-1:0]  req_byte_value,
   input logic                            req_message_start,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ltd8_pkg::KeyWidth-1:0]   rsp_digest_sum,
   input logic [ltd8_pkg::KeyWidth-1:0]   rsp_digest_xor
);

   // A stalled result keeps its digests.
   `LTD8_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_sum) && $stable(rsp_digest_xor))

   // The block only pushes back while a result is pending.
   `LTD8_ASSERT_SAME(a_ready_when_empty, clock, reset, !req_ready, rsp_valid)

   // A zero byte that starts a message yields clear digests on an empty output.
   `LTD8_ASSERT_NEXT(a_zero_start, clock, reset, req_valid && req_ready && req_message_start && (req_byte_value == '0) && !rsp_valid, rsp_valid && (rsp_digest_sum == '0) && (rsp_digest_xor == '0))

   // An accepted item on an empty output shows up in the next cycle.
   `LTD8_ASSERT_NEXT(a_result_latency, clock, reset, req_valid && req_ready && !rsp_valid, rsp_valid)

endmodule

bind lfsr_toeplitz_digest8_core ltd8_checker u_ltd8_checker (.*);

FILE: tb/lfsr_toeplitz_digest8_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr_toeplitz_digest8_core_tb
// Self-checking testbench for the LFSR Toeplitz digest core. A clocked driver
// feeds message bytes from a backlog that the stimulus process fills. A clocked
// monitor compares every returned digest pair with the value that a local
// model of the hash predicts for each accepted byte. Register settings change
// only while the core is idle. Both sides stall at random, and the receiver
// holds off for long stretches so that the core's input backs up.
// ----------------------------------------------------------------------------
module lfsr_toeplitz_digest8_core_tb;
   import ltd8_pkg::*;

   localparam int unsigned QuietLimit   = 1000;
   localparam int unsigned HoldCycles   = 60;
   localparam int unsigned RandomPhases = 11;
   localparam int unsigned PhaseItems   = 150;
   localparam int unsigned MaxReports   = 10;

   typedef struct {
      logic [ByteWidth-1:0] value;
      logic                 start;
   } byte_item_type;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [ByteWidth-1:0]  req_byte_value    = '0;
   logic                  req_message_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [KeyWidth-1:0]   rsp_digest_sum;
   logic [KeyWidth-1:0]   rsp_digest_xor;
   logic                  csr_wr_en         = 1'b0;
   logic [IndexWidth-1:0] csr_index         = '0;
   logic [KeyWidth-1:0]   csr_wr_data       = '0;

   cfg_type       model_cfg   = '0;
   acc_type       model_state = '0;
   byte_item_type byte_backlog[$];
   acc_type       pending_digests[$];

   logic          quiet_tail  = 1'b0;
   int unsigned   send_gap    = 0;
   int unsigned   recv_gap    = 0;
   int unsigned   recv_hold   = 0;
   int unsigned   items_sent  = 0;
   int unsigned   items_queued = 0;
   int unsigned   digests_seen = 0;
   int unsigned   mismatches  = 0;
   int unsigned   cfg_count   = 0;
   int unsigned   quiet_count = 0;

   lfsr_toeplitz_digest8_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_value    (req_byte_value),
      .req_message_start (req_message_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_digest_sum    (rsp_digest_sum),
      .rsp_digest_xor    (rsp_digest_xor),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [KeyWidth-1:0] lfsr_advance(logic [KeyWidth-1:0] k, cfg_type c);
      logic p;
      p = ^(k & c.generator);
      if (c.lfsr_kind) begin
         return c.shift_left ? {k[KeyWidth-2:0], p} : {p, k[KeyWidth-1:1]};
      end else if (c.shift_left) begin
         return {k[KeyWidth-2:0], 1'b0} ^ (k[KeyWidth-1] ? c.generator : '0);
      end else begin
         return {1'b0, k[KeyWidth-1:1]} ^ (k[0] ? c.generator : '0);
      end
   endfunction

   function automatic acc_type hash_byte(acc_type s, cfg_type c, logic [ByteWidth-1:0] b,
                                         logic start);
      int i;
      int pos;
      if (start) begin
         s.key = c.initial_key;
         s.sum = '0;
         s.xr  = '0;
      end
      for (i = 0; i < ByteWidth; i++) begin
         pos = c.msb_first ? (ByteWidth - 1 - i) : i;
         if (b[pos]) begin
            s.sum = s.sum + s.key;
            s.xr  = s.xr ^ s.key;
         end
         s.key = lfsr_advance(s.key, c);
      end
      return s;
   endfunction

   function automatic logic [KeyWidth-1:0] pick_reg8();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         default: return KeyWidth'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            model_state = hash_byte(model_state, model_cfg, req_byte_value, req_message_start);
            pending_digests.push_back(model_state);
            items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
               req_valid         <= 1'b1;
               req_byte_value    <= byte_backlog[0].value;
               req_message_start <= byte_backlog[0].start;
               byte_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            digests_seen++;
            if (pending_digests.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxReports) begin
                  $display("Unexpected digest: sum %02h xor %02h", rsp_digest_sum,
                           rsp_digest_xor);
               end
            end else begin
               if (rsp_digest_sum !== pending_digests[0].sum ||
                   rsp_digest_xor !== pending_digests[0].xr) begin
                  mismatches++;
                  if (mismatches <= MaxReports) begin
                     $display({"Digest mismatch on result %0d: expected sum %02h xor %02h,",
                               " got sum %02h xor %02h"},
                              digests_seen, pending_digests[0].sum, pending_digests[0].xr,
                              rsp_digest_sum, rsp_digest_xor);
                  end
               end
               pending_digests.pop_front();
            end
            if (!quiet_tail && digests_seen % 500 == 0) begin
               recv_hold = HoldCycles;
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_count = 0;
         end else begin
            quiet_count++;
         end
         if (quiet_count >= QuietLimit) begin
            $display("lfsr_toeplitz_digest8_core_tb: done, errors");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [IndexWidth-1:0] idx, input logic [KeyWidth-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic apply_cfg(input logic [KeyWidth-1:0] gen, input logic [KeyWidth-1:0] key,
                            input logic kind, input logic left, input logic msb);
      write_reg(RegGenerator, gen);
      write_reg(RegInitialKey, key);
      write_reg(RegLfsrKind, KeyWidth'(kind));
      write_reg(RegShiftLeft, KeyWidth'(left));
      write_reg(RegMsbFirst, KeyWidth'(msb));
      model_cfg.generator   = gen;
      model_cfg.initial_key = key;
      model_cfg.lfsr_kind   = kind;
      model_cfg.shift_left  = left;
      model_cfg.msb_first   = msb;
      cfg_count++;
   endtask

   task automatic queue_byte(input logic [ByteWidth-1:0] value, input logic start);
      byte_item_type item;
      item.value = value;
      item.start = start;
      byte_backlog.push_back(item);
      items_queued++;
   endtask

   task automatic drain_block();
      while (byte_backlog.size() != 0 || req_valid || pending_digests.size() != 0 ||
             digests_seen < items_queued) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int unsigned          ph;
      int unsigned          n;
      logic                 st;
      logic [ByteWidth-1:0] b;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes ahead of any message start run from the all-zero reset state.
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'hFF, 1'b1);
      drain_block();

      apply_cfg(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h01, 1'b0);
      drain_block();

      apply_cfg(8'h00, 8'h01, 1'b1, 1'b1, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h55, 1'b0);
      drain_block();

      apply_cfg(8'hB8, 8'h80, 1'b1, 1'b0, 1'b0);
      queue_byte(8'hAA, 1'b1);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'hFF, 1'b1);
      drain_block();

      apply_cfg(8'h1D, 8'hE1, 1'b0, 1'b1, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h7E, 1'b0);
      queue_byte(8'hFF, 1'b0);
      drain_block();

      // A register change in the middle of a message applies to later bytes.
      apply_cfg(8'h8E, 8'h5A, 1'b1, 1'b1, 1'b0);
      queue_byte(8'h3C, 1'b0);
      queue_byte(8'hC3, 1'b0);
      drain_block();

      for (ph = 0; ph < RandomPhases; ph++) begin
         if (ph == RandomPhases - 1) begin
            quiet_tail = 1'b1;
         end
         apply_cfg(pick_reg8(), pick_reg8(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         for (n = 0; n < PhaseItems; n++) begin
            st = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 11) == 0);
            if ($urandom_range(0, 7) == 0) begin
               b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else begin
               b = ByteWidth'($urandom);
            end
            queue_byte(b, st);
         end
         drain_block();
      end

      repeat (8) @(posedge clock);
      $display("Fed %0d message bytes under %0d register settings and checked %0d digest pairs.",
               items_sent, cfg_count, digests_seen);
      if (mismatches == 0 && pending_digests.size() == 0) begin
         $display("lfsr_toeplitz_digest8_core_tb: done, clean");
      end else begin
         $display("lfsr_toeplitz_digest8_core_tb: done, errors");
      end
      $finish;
   end

endmodule
